### design/mmhc_pkg.sv
// mmhc_pkg: shared types and constants of the magic multiply hash collision check
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps

package mmhc_pkg;

	localparam int WORD_W         = 64;
	localparam int HALF_W         = 32;
	localparam int CFG_W          = 4;
	localparam int MIN_INDEX_BITS = 4;
	localparam int SLOT_OUT_W     = 10;
	localparam int Q_DEPTH        = 2;
	localparam int Q_PTR_W        = 1;
	localparam int Q_CNT_W        = 2;

	localparam logic [CFG_W-1:0] INDEX_BITS_RESET = 4'd4;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_ENTRY = 1'b1
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_LOOK
	} bk_state_t;

	typedef struct packed {
		logic                  status;
		logic [SLOT_OUT_W-1:0] slot_index;
		logic                  verdict_ready;
	} result_t;

endpackage

### design/mmhc_front.sv
// mmhc_front: input beat acceptance, magic register, split 64 bit multiply, slot index
// depends on mmhc_pkg; feeds mmhc_queue
`timescale 1ns / 1ps

module mmhc_front #(
	parameter int MAX_INDEX_BITS = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             func,
	input  logic [mmhc_pkg::WORD_W-1:0]      magic,
	input  logic [mmhc_pkg::WORD_W-1:0]      occupancy,
	input  logic [mmhc_pkg::WORD_W-1:0]      moves,
	input  logic                             final_entry,
	input  logic [mmhc_pkg::CFG_W-1:0]       index_bits,
	input  logic                             q_full,
	output logic                             q_push,
	output logic [MAX_INDEX_BITS+mmhc_pkg::WORD_W+1:0] q_wdata
);
	import mmhc_pkg::*;

	logic                accept;
	logic                s1_vld;
	cmd_t                cmd_s1;
	logic                final_s1;
	logic [WORD_W-1:0]   moves_s1;
	logic [WORD_W-1:0]   p_ll_s1;
	logic [HALF_W-1:0]   p_lh_s1;
	logic [HALF_W-1:0]   p_hl_s1;
	logic [WORD_W-1:0]   magic_q;
	logic [WORD_W-1:0]   product;
	logic [HALF_W-1:0]   cross_sum;
	logic [7:0]          cfg8;
	logic [7:0]          k8;
	logic [6:0]          sh;
	logic [WORD_W-1:0]   shifted;
	logic [MAX_INDEX_BITS-1:0] slot;

	assign in_ready = !s1_vld || !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = s1_vld && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld  <= 1'b0;
			magic_q <= '0;
		end else begin
			if (accept) begin
				s1_vld <= 1'b1;
				if (cmd_t'(func) == CMD_START) begin
					magic_q <= magic;
				end
			end else if (q_push) begin
				s1_vld <= 1'b0;
			end
		end
	end

	// partial products of the low 64 bits, with the command, final flag and moves
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= cmd_t'(func);
			final_s1 <= final_entry;
			moves_s1 <= moves;
			p_ll_s1  <= occupancy[HALF_W-1:0] * magic_q[HALF_W-1:0];
			p_lh_s1  <= HALF_W'(occupancy[HALF_W-1:0] * magic_q[WORD_W-1:HALF_W]);
			p_hl_s1  <= HALF_W'(occupancy[WORD_W-1:HALF_W] * magic_q[HALF_W-1:0]);
		end
	end

	always_comb begin
		cross_sum = p_lh_s1 + p_hl_s1;
		product   = p_ll_s1 + {cross_sum, {HALF_W{1'b0}}};
		cfg8    = 8'(index_bits);
		if (cfg8 < 8'(MIN_INDEX_BITS)) begin
			k8 = 8'(MIN_INDEX_BITS);
		end else if (cfg8 > 8'(MAX_INDEX_BITS)) begin
			k8 = 8'(MAX_INDEX_BITS);
		end else begin
			k8 = cfg8;
		end
		sh      = 7'(WORD_W) - 7'(k8);
		shifted = product >> sh;
		if (cmd_s1 == CMD_START) begin
			slot = '0;
		end else begin
			slot = MAX_INDEX_BITS'(shifted);
		end
		q_wdata = {cmd_s1, final_s1, moves_s1, slot};
	end

endmodule

### design/mmhc_queue.sv
// mmhc_queue: two entry queue between the front and the back
// depends on mmhc_pkg for depth constants
`timescale 1ns / 1ps

module mmhc_queue #(
	parameter int DATA_W = 76
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [DATA_W-1:0]            wdata,
	output logic                         full,
	input  logic                         pop,
	output logic [DATA_W-1:0]            rdata,
	output logic                         not_empty,
	output logic [mmhc_pkg::Q_CNT_W-1:0] level
);
	import mmhc_pkg::*;

	logic [DATA_W-1:0]  store_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign full      = cnt_q == Q_CNT_W'(Q_DEPTH);
	assign not_empty = cnt_q != '0;
	assign rdata     = store_q[rd_ptr_q];
	assign level     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

### design/mmhc_back.sv
// mmhc_back: slot table with row valid bits, sticky failure flag, result register
// depends on mmhc_pkg; drained from mmhc_queue
`timescale 1ns / 1ps

module mmhc_back #(
	parameter int MAX_INDEX_BITS = 10
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       q_valid,
	input  logic [MAX_INDEX_BITS+mmhc_pkg::WORD_W+1:0] q_rdata,
	output logic                                       q_pop,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output mmhc_pkg::result_t                          res
);
	import mmhc_pkg::*;

	localparam int Q_W      = MAX_INDEX_BITS + WORD_W + 2;
	localparam int ROW_BITS = (MAX_INDEX_BITS > 9) ? MAX_INDEX_BITS - 8 : 1;
	localparam int ADDR_W   = MAX_INDEX_BITS - ROW_BITS;
	localparam int ROWS     = 1 << ADDR_W;
	localparam int ROW_W    = WORD_W << ROW_BITS;

	bk_state_t state_q, state_d;

	cmd_t                      h_cmd;
	logic                      h_final;
	logic [WORD_W-1:0]         h_moves;
	logic [MAX_INDEX_BITS-1:0] h_slot;

	logic                      failed_q;
	logic [ROWS-1:0]           row_vld_q;
	logic                      out_vld_q;
	result_t                   res_q;
	result_t                   res_d;
	logic [MAX_INDEX_BITS-1:0] slot_q;
	logic [WORD_W-1:0]         moves_q;
	logic                      final_q;
	logic [ROW_W-1:0]          rd_row_q;
	logic [ROW_W-1:0]          mem [ROWS];

	logic                      out_free;
	logic                      load;
	logic                      latch;
	logic                      clr;
	logic                      rd_en;
	logic                      wr_en;
	logic                      set_fail;
	logic [ADDR_W-1:0]         row_sel;
	logic [ROW_BITS-1:0]       col_sel;
	logic [ROW_W-1:0]          base_row;
	logic [ROW_W-1:0]          wr_row;
	logic [WORD_W-1:0]         cur;

	assign h_cmd     = cmd_t'(q_rdata[Q_W-1]);
	assign {h_final, h_moves, h_slot} = q_rdata[Q_W-2:0];
	assign out_free  = !out_vld_q || out_ready;
	assign row_sel   = slot_q[MAX_INDEX_BITS-1:ROW_BITS];
	assign col_sel   = slot_q[ROW_BITS-1:0];
	assign out_valid = out_vld_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load     = 1'b0;
		latch    = 1'b0;
		clr      = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		set_fail = 1'b0;
		res_d    = '0;
		base_row = row_vld_q[row_sel] ? rd_row_q : '0;
		cur      = base_row[col_sel*WORD_W +: WORD_W];
		wr_row   = base_row;
		wr_row[col_sel*WORD_W +: WORD_W] = moves_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					if (h_cmd == CMD_START) begin
						clr  = 1'b1;
						load = 1'b1;
					end else if (failed_q) begin
						load                = 1'b1;
						res_d.status        = 1'b1;
						res_d.slot_index    = SLOT_OUT_W'(h_slot);
						res_d.verdict_ready = h_final;
					end else begin
						latch   = 1'b1;
						rd_en   = 1'b1;
						state_d = BK_LOOK;
					end
				end
			end
			BK_LOOK: begin
				if (cur == '0) begin
					wr_en = 1'b1;
				end else if (cur != moves_q) begin
					set_fail = 1'b1;
				end
				load                = 1'b1;
				res_d.status        = set_fail;
				res_d.slot_index    = SLOT_OUT_W'(slot_q);
				res_d.verdict_ready = final_q;
				state_d             = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			failed_q  <= 1'b0;
			row_vld_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (clr) begin
				failed_q  <= 1'b0;
				row_vld_q <= '0;
			end else begin
				if (set_fail) begin
					failed_q <= 1'b1;
				end
				if (wr_en) begin
					row_vld_q[row_sel] <= 1'b1;
				end
			end
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
		if (latch) begin
			slot_q  <= h_slot;
			moves_q <= h_moves;
			final_q <= h_final;
		end
	end

	// slot table, one row per address
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[row_sel] <= wr_row;
		end
		if (rd_en) begin
			rd_row_q <= mem[h_slot[MAX_INDEX_BITS-1:ROW_BITS]];
		end
	end

endmodule

### design/magic_multiply_hash_collision_check.sv
// magic_multiply_hash_collision_check: top level, index width register and assertions
// depends on mmhc_pkg, mmhc_front, mmhc_queue, mmhc_back
// channel | signals                            | beat when
// in      | in_valid in_ready, five fields     | in_valid && in_ready
// out     | out_valid out_ready, three fields  | out_valid && out_ready
// cfg     | cfg_we cfg_wdata                   | cfg_we
// a start or post-fail entry answers from idle; other entries read a row, may write it
// the front registers the split multiply partial products, then takes one queue slot
// after reset the table reads as zero at once, as all row valid bits are cleared
// either side may stall, the queue and the result register absorb the difference
`timescale 1ns / 1ps

module magic_multiply_hash_collision_check #(
	parameter int MAX_INDEX_BITS = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic [mmhc_pkg::WORD_W-1:0]       magic,
	input  logic [mmhc_pkg::WORD_W-1:0]       occupancy,
	input  logic [mmhc_pkg::WORD_W-1:0]       moves,
	input  logic                              final_entry,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              status,
	output logic [mmhc_pkg::SLOT_OUT_W-1:0]   slot_index,
	output logic                              verdict_ready,
	input  logic                              cfg_we,
	input  logic [mmhc_pkg::CFG_W-1:0]        cfg_wdata
);
	import mmhc_pkg::*;

	localparam int Q_W = MAX_INDEX_BITS + WORD_W + 2;

	logic [CFG_W-1:0]   index_bits_q;
	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_valid;
	logic [Q_CNT_W-1:0] q_level;
	logic [Q_W-1:0]     q_wdata;
	logic [Q_W-1:0]     q_rdata;
	result_t            res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q <= INDEX_BITS_RESET;
		end else if (cfg_we) begin
			index_bits_q <= cfg_wdata;
		end
	end

	mmhc_front #(
		.MAX_INDEX_BITS(MAX_INDEX_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.magic       (magic),
		.occupancy   (occupancy),
		.moves       (moves),
		.final_entry (final_entry),
		.index_bits  (index_bits_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_wdata     (q_wdata)
	);

	mmhc_queue #(
		.DATA_W(Q_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.rdata     (q_rdata),
		.not_empty (q_valid),
		.level     (q_level)
	);

	mmhc_back #(
		.MAX_INDEX_BITS(MAX_INDEX_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign status        = res.status;
	assign slot_index    = res.slot_index;
	assign verdict_ready = res.verdict_ready;

	a_queue_level: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= Q_CNT_W'(Q_DEPTH))
		else $error("queue level beyond depth");

	a_pop_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_valid && (!out_valid || out_ready)))
		else $error("queue popped without data or result room");

	a_start_result: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && cmd_t'(q_rdata[Q_W-1]) == CMD_START) |=>
		(out_valid && !status && slot_index == '0 && !verdict_ready))
		else $error("start beat gave a wrong result");

endmodule
